@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define MPQ_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/mpq_pkg.sv @@
`default_nettype none

package mpq_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic               command;
      logic signed [31:0] in_data;
      logic        [7:0]  in_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_data;
      logic        [7:0]  out_priority;
      status_type         status;
      logic        [7:0]  top_priority;
      logic        [7:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic        [7:0]  prio;
   } entry_type;

   // best entry seen so far along the chain
   typedef struct packed {
      logic               found;
      logic        [7:0]  prio;
      logic signed [31:0] data;
   } wave_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } op_type;

endpackage

`default_nettype wire

@@ rtl/core/mpq_cell.sv @@
`default_nettype none

module mpq_cell import mpq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int INDEX = 0,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire op_type          op,
   input  wire logic [CW-1:0]   count,
   input  wire logic [IW-1:0]   rem_idx,
   input  wire entry_type       new_entry,
   input  wire entry_type       next_entry,
   output      entry_type       entry,
   input  wire wave_type        wave_in,
   input  wire logic [IW-1:0]   wave_idx_in,
   output      wave_type        wave_out,
   output      logic [IW-1:0]   wave_idx_out
);

   localparam logic [CW-1:0] MY_POS = CW'(INDEX);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   entry_type     entry_ff, entry_in;
   wave_type      wave_ff, wave_next_in;
   logic [IW-1:0] widx_ff, widx_in;
   logic          occupied;

   assign occupied = MY_POS < count;

   always_comb begin
      entry_in = entry_ff;
      if (op.insert && (count == MY_POS)) begin
         entry_in = new_entry;
      end else if (op.remove && (MY_IDX >= rem_idx)) begin
         // close the gap left by the removed item
         entry_in = next_entry;
      end
   end

   // strict compare keeps the earliest of equal priorities
   always_comb begin
      wave_next_in = wave_in;
      widx_in      = wave_idx_in;
      if (occupied && (!wave_in.found || (entry_ff.prio > wave_in.prio))) begin
         wave_next_in.found = 1'b1;
         wave_next_in.prio  = entry_ff.prio;
         wave_next_in.data  = entry_ff.data;
         widx_in            = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      widx_ff  <= widx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_next_in;
      end
   end

   assign entry        = entry_ff;
   assign wave_out     = wave_ff;
   assign wave_idx_out = widx_ff;

endmodule

`default_nettype wire

@@ rtl/core/max_priority_queue.sv @@
// Channel  | Ports                           | Direction | Payload
// request  | req_valid req_stall req_data    | in        | req_type
// response | rsp_valid rsp_stall rsp_data    | out       | rsp_type
//
// Each item is accepted in ST_IDLE, then passes ST_SETTLE and ST_EMIT before the next
// accept; ST_EMIT waits while an earlier result is held by rsp_stall. The accept edge
// updates the cell row, ST_SETTLE lets the max search ripple through the registered
// chain of DEPTH cells, and ST_EMIT registers the result offered on rsp_valid.
// Reset (synchronous) empties the queue; the search chain is settled at once.
// A new item may be accepted while the previous result waits on rsp_stall.
`default_nettype none
`include "assert_macros.svh"

module max_priority_queue import mpq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   fsm_state_type state_ff, state_in;
   logic [IW-1:0] settle_cnt_ff, settle_cnt_in;
   logic [CW-1:0] count_ff, count_in;
   status_type    pend_status_ff, pend_status_in;
   entry_type     pend_entry_ff, pend_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          emit_fire;
   logic          rsp_empty;
   op_type        op;
   entry_type     new_entry;

   entry_type     entry_w [DEPTH];
   wave_type      wave_w [DEPTH+1];
   logic [IW-1:0] wave_idx_w [DEPTH+1];

   assign wave_w[0]     = '0;
   assign wave_idx_w[0] = '0;

   assign new_entry.data = req_data.in_data;
   assign new_entry.prio = req_data.in_priority;

   assign op.insert = accept && (req_data.command == CMD_INSERT) && (count_ff != CW'(DEPTH));
   assign op.remove = accept && (req_data.command == CMD_REMOVE) && (count_ff != '0);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mpq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .op           (op),
         .count        (count_ff),
         .rem_idx      (wave_idx_w[DEPTH]),
         .new_entry    (new_entry),
         .next_entry   ((i < DEPTH - 1) ? entry_w[(i < DEPTH - 1) ? i + 1 : i] : entry_w[i]),
         .entry        (entry_w[i]),
         .wave_in      (wave_w[i]),
         .wave_idx_in  (wave_idx_w[i]),
         .wave_out     (wave_w[i+1]),
         .wave_idx_out (wave_idx_w[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            if (settle_cnt_ff == IW'(DEPTH - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      emit_fire = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SETTLE: req_stall = 1'b1;
         ST_EMIT:   emit_fire = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      settle_cnt_in = (state_ff == ST_SETTLE) ? settle_cnt_ff + IW'(1) : '0;

      count_in = count_ff;
      if (op.insert) count_in = count_ff + CW'(1);
      else if (op.remove) count_in = count_ff - CW'(1);

      pend_status_in = pend_status_ff;
      pend_entry_in  = pend_entry_ff;
      if (accept) begin
         pend_status_in     = STATUS_DONE;
         pend_entry_in      = '0;
         if (req_data.command == CMD_INSERT) begin
            if (!op.insert) pend_status_in = STATUS_FULL;
         end else if (!op.remove) begin
            pend_status_in = STATUS_EMPTY;
         end else begin
            // chain end holds the earliest highest entry while idle
            pend_entry_in.data = wave_w[DEPTH].data;
            pend_entry_in.prio = wave_w[DEPTH].prio;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;

      rsp_data_in = rsp_data_ff;
      if (emit_fire) begin
         rsp_data_in.out_data     = pend_entry_ff.data;
         rsp_data_in.out_priority = pend_entry_ff.prio;
         rsp_data_in.status       = pend_status_ff;
         rsp_data_in.top_priority = wave_w[DEPTH].found ? wave_w[DEPTH].prio : 8'd0;
         rsp_data_in.occupancy    = 8'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         settle_cnt_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         settle_cnt_ff <= settle_cnt_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_entry_ff  <= pend_entry_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_empty = rsp_valid && (rsp_data.status == STATUS_EMPTY);

   `MPQ_ASSERT(a_count_range, count_ff <= CW'(DEPTH), "occupancy above depth")
   `MPQ_ASSERT_NEXT(a_accept_settles, accept, state_ff == ST_SETTLE, "accept did not start search")
   `MPQ_ASSERT_NEXT(a_insert_grows, op.insert, count_ff == $past(count_ff) + CW'(1), "insert lost")
   `MPQ_ASSERT(a_empty_zero, rsp_empty |-> (rsp_data.occupancy == 8'd0), "empty status with entries")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top import mpq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH       = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = QDEPTH + 20;
   localparam int RANDOM_ITEMS = 720;
   localparam int PHASE_LEN    = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   max_priority_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the queue, kept in arrival order
   logic signed [31:0] shadow_data [QDEPTH];
   logic        [7:0]  shadow_prio [QDEPTH];
   int                 shadow_count = 0;

   rsp_type awaited_results [$];

   int  fail_count   = 0;
   int  cycle_count  = 0;
   int  checked      = 0;
   int  n_insert     = 0;
   int  n_remove     = 0;
   int  n_full       = 0;
   int  n_empty      = 0;
   int  peak_count   = 0;
   bit  send_quiet   = 1'b0;
   bit  recv_quiet   = 1'b0;
   int  stall_left   = 0;

   // earliest slot holding the highest priority; needs shadow_count > 0
   function automatic int top_slot();
      int best;
      best = 0;
      for (int i = 1; i < shadow_count; i++)
         if (shadow_prio[i] > shadow_prio[best]) best = i;
      return best;
   endfunction

   function automatic rsp_type predict_queue_op(input req_type item);
      rsp_type r;
      int      k;
      r = '0;
      r.status = STATUS_DONE;
      if (item.command == CMD_INSERT) begin
         if (shadow_count >= QDEPTH) begin
            r.status = STATUS_FULL;
            n_full++;
         end else begin
            shadow_data[shadow_count] = item.in_data;
            shadow_prio[shadow_count] = item.in_priority;
            shadow_count++;
            n_insert++;
         end
      end else if (shadow_count == 0) begin
         r.status = STATUS_EMPTY;
         n_empty++;
      end else begin
         k = top_slot();
         r.out_data     = shadow_data[k];
         r.out_priority = shadow_prio[k];
         for (int j = k; j < shadow_count - 1; j++) begin
            shadow_data[j] = shadow_data[j + 1];
            shadow_prio[j] = shadow_prio[j + 1];
         end
         shadow_count--;
         n_remove++;
      end
      if (shadow_count > 0) r.top_priority = shadow_prio[top_slot()];
      r.occupancy = 8'(shadow_count);
      if (shadow_count > peak_count) peak_count = shadow_count;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result arrived with no item outstanding");
         return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (got.out_data !== want.out_data)
         report_mismatch($sformatf("out_data %0d, want %0d", got.out_data, want.out_data));
      if (got.out_priority !== want.out_priority)
         report_mismatch($sformatf("out_priority %0d, want %0d",
                                   got.out_priority, want.out_priority));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, want %0d",
                                   2'(got.status), 2'(want.status)));
      if (got.top_priority !== want.top_priority)
         report_mismatch($sformatf("top_priority %0d, want %0d",
                                   got.top_priority, want.top_priority));
      if (got.occupancy !== want.occupancy)
         report_mismatch($sformatf("occupancy %0d, want %0d",
                                   got.occupancy, want.occupancy));
   endtask

   // stall count is spent only while a result is on offer
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
            stall_left = recv_quiet ? 0 : $urandom_range(0, 14);
         end else if (rsp_valid && stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // valid stays high after an accept; it drops only when a gap follows
   task automatic send_item(input req_type item);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      awaited_results.push_back(predict_queue_op(item));
   endtask

   function automatic req_type make_item(input logic cmd, input logic signed [31:0] d,
                                         input logic [7:0] p);
      req_type r;
      r.command     = cmd;
      r.in_data     = d;
      r.in_priority = p;
      return r;
   endfunction

   function automatic logic [7:0] rand_prio();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 3));
         1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic signed [31:0] rand_data();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      send_item(make_item(CMD_REMOVE, 32'sd0, 8'd0));             // remove from empty
      send_item(make_item(CMD_INSERT, 32'sh8000_0000, 8'd0));
      send_item(make_item(CMD_INSERT, 32'sh7FFF_FFFF, 8'd255));
      send_item(make_item(CMD_INSERT, 32'sd0, 8'd255));           // tie on top
      send_item(make_item(CMD_INSERT, -32'sd1, 8'd128));
      send_item(make_item(CMD_INSERT, 32'sd1, 8'd0));             // tie on bottom
      repeat (5) send_item(make_item(CMD_REMOVE, -32'sd1, 8'hFF));
      send_item(make_item(CMD_REMOVE, 32'sh5555_5555, 8'h55));
      send_item(make_item(CMD_INSERT, 32'sh5555_5555, 8'h55));
      send_item(make_item(CMD_INSERT, 32'shAAAA_AAAA, 8'hAA));
      send_item(make_item(CMD_INSERT, 32'sh1234_5678, 8'h55));
      repeat (3) send_item(make_item(CMD_REMOVE, 32'shAAAA_AAAA, 8'hAA));
   endtask

   task automatic test_fill_and_drain();
      for (int i = 0; i < QDEPTH; i++)
         send_item(make_item(CMD_INSERT, rand_data(), 8'($urandom_range(0, 15))));
      send_item(make_item(CMD_INSERT, 32'sh7FFF_FFFF, 8'hFF));    // refused, full
      send_item(make_item(CMD_INSERT, 32'sh8000_0000, 8'h00));
      for (int i = 0; i < QDEPTH + 2; i++)
         send_item(make_item(CMD_REMOVE, rand_data(), rand_prio()));
   endtask

   task automatic test_random_mix();
      int insert_pct;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0) begin
            insert_pct = ((i / PHASE_LEN) % 2 == 0) ? 80 : 30;
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(1, 100) <= insert_pct)
            send_item(make_item(CMD_INSERT, rand_data(), rand_prio()));
         else
            send_item(make_item(CMD_REMOVE, rand_data(), rand_prio()));
      end
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_random_mix();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d results: %0d inserts, %0d removes, %0d full refusals, %0d empty",
               checked, n_insert, n_remove, n_full, n_empty);
      $display("queue reached %0d of %0d entries; %0d mismatches",
               peak_count, QDEPTH, fail_count);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
